### src/tcd_pkg.sv
package tcd_pkg;

  localparam int unsigned LOOKAHEAD = 8;
  localparam int unsigned HEAD_LEN = 3;

  localparam logic [1:0] CFG_CLOCK_EN = 2'd0;
  localparam logic [1:0] CFG_DISPLAY_EN = 2'd1;
  localparam logic [1:0] CFG_CONTRAST = 2'd2;

  localparam logic [3:0] ACT_SEC = 4'd0;
  localparam logic [3:0] ACT_MIN = 4'd1;
  localparam logic [3:0] ACT_HOUR = 4'd2;
  localparam logic [3:0] ACT_DAY = 4'd3;
  localparam logic [3:0] ACT_MONTH = 4'd4;
  localparam logic [3:0] ACT_YEAR = 4'd5;
  localparam logic [3:0] ACT_CONTRAST = 4'd6;
  localparam logic [3:0] ACT_LED_ON = 4'd7;
  localparam logic [3:0] ACT_LED_OFF = 4'd8;

  localparam logic [7:0] CHR_LS = "s";
  localparam logic [7:0] CHR_LC = "c";
  localparam logic [7:0] CHR_LM = "m";
  localparam logic [7:0] CHR_LH = "h";
  localparam logic [7:0] CHR_LD = "d";
  localparam logic [7:0] CHR_UM = "M";
  localparam logic [7:0] CHR_UY = "Y";
  localparam logic [7:0] CHR_LE = "e";
  localparam logic [7:0] CHR_LO = "o";
  localparam logic [7:0] CHR_UO = "O";
  localparam logic [7:0] CHR_LI = "i";
  localparam logic [7:0] CHR_LN = "n";
  localparam logic [7:0] CHR_UN = "N";
  localparam logic [7:0] CHR_LF = "f";
  localparam logic [7:0] CHR_UF = "F";
  localparam logic [3:0] DIGIT_HI = 4'h3;
  localparam logic [3:0] DIGIT_MAX = 4'd9;

  localparam logic [7:0] CONTRAST_RESET = 8'hFF;
  localparam logic [7:0] CONTRAST_STEP = 8'h20;
  localparam logic [7:0] CONTRAST_UP_LIMIT = 8'hDF;
  localparam logic [7:0] CONTRAST_MAX = 8'hFF;
  localparam logic [7:0] CONTRAST_MIN = 8'h00;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       end_of_packet;
  } in_t;

  typedef struct packed {
    logic [3:0]  action;
    logic [13:0] action_value;
    logic [7:0]  status_first;
    logic [7:0]  status_second;
    logic [7:0]  status_third;
    logic        last_of_run;
  } out_t;

  typedef struct packed {
    logic [LOOKAHEAD-1:0][7:0] bytes;
    logic [3:0]                count;
    logic [LOOKAHEAD-1:0]      mask;
    logic [HEAD_LEN-1:0][7:0]  head;
  } job_t;

  typedef struct packed {
    logic        match;
    logic [3:0]  action;
    logic [13:0] value;
    logic        up;
  } pos_res_t;

endpackage

### src/text_command_decoder_core.sv
// Each accepted beat is registered, then its byte positions are decoded from that register;
// the first result then enters the output register once the output is free. A beat that
// causes k results (k up to 8 at the end of a packet) holds the decoder until all are out,
// one result per cycle unless the output stalls; beats without results flow one per cycle.
// Reset clears the window, packet head and valid flags, sets both enables to one and
// loads the contrast with 255.
module text_command_decoder_core import tcd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  in_t        in_data_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output out_t       out_data_o,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_data_i
);

  job_t                 job;
  logic                 job_valid, job_release, in_fire;
  pos_res_t [LOOKAHEAD-1:0] res;
  logic [LOOKAHEAD-1:0] match_vec, pending, sel, remaining;
  logic [LOOKAHEAD-1:0] done_q, done_d;
  logic                 emit, out_free;
  logic                 clock_en_q, display_en_q;
  logic [7:0]           contrast_q, contrast_d, contrast_new;
  logic                 out_valid_q, out_valid_d;
  out_t                 out_data_q, out_data_d;
  pos_res_t             chosen;

  assign in_fire = in_valid_i && !in_stall_o;

  tcd_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_fire_i     (in_fire),
    .in_data_i     (in_data_i),
    .job_release_i (job_release),
    .job_o         (job),
    .job_valid_o   (job_valid)
  );

  for (genvar p = 0; p < LOOKAHEAD; p++) begin : g_pos
    logic [LOOKAHEAD-1:0][7:0] pbytes;
    logic [LOOKAHEAD-1:0]      ppresent;
    for (genvar k = 0; k < LOOKAHEAD; k++) begin : g_byte
      if (p + k < LOOKAHEAD) begin : g_in
        assign pbytes[k] = job.bytes[p+k];
        assign ppresent[k] = 4'(p + k) < job.count;
      end else begin : g_out
        assign pbytes[k] = '0;
        assign ppresent[k] = 1'b0;
      end
    end
    tcd_pos_decode u_dec (
      .bytes_i      (pbytes),
      .present_i    (ppresent),
      .clock_en_i   (clock_en_q),
      .display_en_i (display_en_q),
      .res_o        (res[p])
    );
    assign match_vec[p] = res[p].match && job.mask[p];
  end

  always_comb begin
    pending = match_vec & ~done_q;
    sel = pending & (~pending + LOOKAHEAD'(1));
    remaining = pending & ~sel;
    out_free = !out_valid_q || !out_stall_i;
    emit = job_valid && (pending != '0) && out_free;
    job_release = job_valid && ((pending == '0) || (emit && (remaining == '0)));
    in_stall_o = job_valid && !job_release;

    done_d = done_q;
    if (emit) begin
      done_d = done_q | sel;
    end
    if (in_fire) begin
      done_d = '0;
    end

    chosen = '0;
    for (int p = 0; p < LOOKAHEAD; p++) begin
      if (sel[p]) begin
        chosen = res[p];
      end
    end

    if (chosen.up) begin
      contrast_new = (contrast_q < CONTRAST_UP_LIMIT) ? contrast_q + CONTRAST_STEP
                                                      : CONTRAST_MAX;
    end else begin
      contrast_new = (contrast_q >= CONTRAST_STEP) ? contrast_q - CONTRAST_STEP
                                                   : CONTRAST_MIN;
    end

    contrast_d = contrast_q;
    if (emit && (chosen.action == ACT_CONTRAST)) begin
      contrast_d = contrast_new;
    end
    if (cfg_we_i && (cfg_index_i == CFG_CONTRAST)) begin
      contrast_d = cfg_data_i;
    end

    out_data_d = out_data_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (emit) begin
      out_valid_d = 1'b1;
      out_data_d = '0;
      out_data_d.action = chosen.action;
      out_data_d.action_value = chosen.value;
      out_data_d.last_of_run = (remaining == '0);
      if (chosen.action == ACT_CONTRAST) begin
        out_data_d.action_value = {6'd0, contrast_new};
      end
      if (chosen.action == ACT_LED_ON || chosen.action == ACT_LED_OFF) begin
        out_data_d.status_first = job.head[0];
        out_data_d.status_second = job.head[1];
      end
      if (chosen.action == ACT_LED_OFF) begin
        out_data_d.status_third = job.head[2];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= '0;
      out_valid_q <= 1'b0;
      clock_en_q <= 1'b1;
      display_en_q <= 1'b1;
      contrast_q <= CONTRAST_RESET;
    end else begin
      done_q <= done_d;
      out_valid_q <= out_valid_d;
      contrast_q <= contrast_d;
      if (cfg_we_i && (cfg_index_i == CFG_CLOCK_EN)) begin
        clock_en_q <= cfg_data_i[0];
      end
      if (cfg_we_i && (cfg_index_i == CFG_DISPLAY_EN)) begin
        display_en_q <= cfg_data_i[0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o = out_data_q;

endmodule

### src/tcd_front.sv
module tcd_front import tcd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_fire_i,
  input  in_t  in_data_i,
  input  logic job_release_i,
  output job_t job_o,
  output logic job_valid_o
);

  logic [LOOKAHEAD-2:0][7:0] win_q, win_d;
  logic [2:0]                fill_q, fill_d;
  logic [HEAD_LEN-1:0][7:0]  head_q, head_d;
  logic [1:0]                head_cnt_q, head_cnt_d;
  job_t                      job_q, job_d;
  logic                      job_valid_q, job_valid_d;

  always_comb begin
    job_d = job_q;
    win_d = win_q;
    fill_d = fill_q;
    head_d = head_q;
    head_cnt_d = head_cnt_q;
    job_valid_d = job_valid_q;
    if (job_release_i) begin
      job_valid_d = 1'b0;
    end
    if (in_fire_i) begin
      job_valid_d = 1'b1;
      for (int k = 0; k < LOOKAHEAD - 1; k++) begin
        job_d.bytes[k] = (4'(k) < {1'b0, fill_q}) ? win_q[k] : in_data_i.rx_byte;
      end
      job_d.bytes[LOOKAHEAD-1] = in_data_i.rx_byte;
      job_d.count = {1'b0, fill_q} + 4'd1;
      if (head_cnt_q != 2'(HEAD_LEN)) begin
        head_d[head_cnt_q] = in_data_i.rx_byte;
        head_cnt_d = head_cnt_q + 2'd1;
      end
      job_d.head = head_d;
      if (in_data_i.end_of_packet) begin
        for (int p = 0; p < LOOKAHEAD; p++) begin
          job_d.mask[p] = 4'(p) < job_d.count;
        end
        fill_d = 3'd0;
        head_cnt_d = 2'd0;
        head_d = '0;
      end else if (fill_q == 3'(LOOKAHEAD - 1)) begin
        job_d.mask = LOOKAHEAD'(1);
        for (int k = 0; k < LOOKAHEAD - 1; k++) begin
          win_d[k] = job_d.bytes[k+1];
        end
      end else begin
        job_d.mask = '0;
        for (int k = 0; k < LOOKAHEAD - 1; k++) begin
          win_d[k] = job_d.bytes[k];
        end
        fill_d = fill_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
      fill_q <= 3'd0;
      head_q <= '0;
      head_cnt_q <= 2'd0;
      job_valid_q <= 1'b0;
    end else begin
      win_q <= win_d;
      fill_q <= fill_d;
      head_q <= head_d;
      head_cnt_q <= head_cnt_d;
      job_valid_q <= job_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
  end

  assign job_o = job_q;
  assign job_valid_o = job_valid_q;

endmodule

### src/tcd_pos_decode.sv
module tcd_pos_decode import tcd_pkg::*; (
  input  logic [LOOKAHEAD-1:0][7:0] bytes_i,
  input  logic [LOOKAHEAD-1:0]      present_i,
  input  logic                      clock_en_i,
  input  logic                      display_en_i,
  output pos_res_t                  res_o
);

  logic [LOOKAHEAD-1:0] dig;
  logic [LOOKAHEAD-1:0][3:0] dv;
  logic is_s, is_lo, is_uo, clock_hit, year_hit, time_hit, code_ok, disp_hit;
  logic on_hit, off_hit;
  logic [3:0] code;

  function automatic logic eq(input logic [7:0] b, input logic p, input logic [7:0] ch);
    eq = p && (b == ch);
  endfunction

  always_comb begin
    for (int k = 0; k < LOOKAHEAD; k++) begin
      dig[k] = present_i[k] && (bytes_i[k][7:4] == DIGIT_HI) && (bytes_i[k][3:0] <= DIGIT_MAX);
      dv[k] = bytes_i[k][3:0];
    end
    is_s = eq(bytes_i[0], present_i[0], CHR_LS);
    is_lo = eq(bytes_i[0], present_i[0], CHR_LO);
    is_uo = eq(bytes_i[0], present_i[0], CHR_UO);
    clock_hit = is_s && eq(bytes_i[1], present_i[1], CHR_LC) && clock_en_i;
    year_hit = clock_hit && eq(bytes_i[2], present_i[2], CHR_UY) && dig[3] && dig[4]
               && dig[5] && dig[6] && eq(bytes_i[7], present_i[7], CHR_LE);
    code_ok = 1'b1;
    code = ACT_SEC;
    if (eq(bytes_i[2], present_i[2], CHR_LS)) begin
      code = ACT_SEC;
    end else if (eq(bytes_i[2], present_i[2], CHR_LM)) begin
      code = ACT_MIN;
    end else if (eq(bytes_i[2], present_i[2], CHR_LH)) begin
      code = ACT_HOUR;
    end else if (eq(bytes_i[2], present_i[2], CHR_LD)) begin
      code = ACT_DAY;
    end else if (eq(bytes_i[2], present_i[2], CHR_UM)) begin
      code = ACT_MONTH;
    end else begin
      code_ok = 1'b0;
    end
    time_hit = clock_hit && code_ok && dig[3] && dig[4] && eq(bytes_i[5], present_i[5], CHR_LE);
    disp_hit = is_s && eq(bytes_i[1], present_i[1], CHR_LO) && display_en_i
               && eq(bytes_i[3], present_i[3], CHR_LE)
               && (eq(bytes_i[2], present_i[2], CHR_LI) || eq(bytes_i[2], present_i[2], CHR_LD));
    on_hit = (is_lo && eq(bytes_i[1], present_i[1], CHR_LN))
             || (is_uo && eq(bytes_i[1], present_i[1], CHR_UN));
    off_hit = (is_lo && eq(bytes_i[1], present_i[1], CHR_LF) && eq(bytes_i[2], present_i[2], CHR_LF))
              || (is_uo && eq(bytes_i[1], present_i[1], CHR_UF)
                  && eq(bytes_i[2], present_i[2], CHR_UF));

    res_o = '0;
    res_o.up = eq(bytes_i[2], present_i[2], CHR_LI);
    if (year_hit) begin
      res_o.match = 1'b1;
      res_o.action = ACT_YEAR;
      res_o.value = 14'(dv[3]) * 14'd1000 + 14'(dv[4]) * 14'd100 + 14'(dv[5]) * 14'd10
                    + 14'(dv[6]);
    end else if (time_hit) begin
      res_o.match = 1'b1;
      res_o.action = code;
      res_o.value = 14'(dv[3]) * 14'd10 + 14'(dv[4]);
    end else if (disp_hit) begin
      res_o.match = 1'b1;
      res_o.action = ACT_CONTRAST;
    end else if (on_hit) begin
      res_o.match = 1'b1;
      res_o.action = ACT_LED_ON;
    end else if (off_hit) begin
      res_o.match = 1'b1;
      res_o.action = ACT_LED_OFF;
    end
  end

endmodule

### tb/text_command_decoder_core_tb.sv
`timescale 1ns / 1ps

module text_command_decoder_core_tb;
  import tcd_pkg::*;

  localparam logic [1:0] CFG_SPARE = 2'd3;
  localparam logic [8:0] NO_CHAR = 9'h100;
  localparam int SETTLE_CYCLES = 12;
  localparam int HOLD_CYCLES = 300;
  localparam int QUIET_LIMIT = 2000;
  localparam int PRINT_LIMIT = 100;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  in_t        in_data_i;
  logic       out_valid_o;
  logic       out_stall_i;
  out_t       out_data_o;
  logic       cfg_we_i;
  logic [1:0] cfg_index_i;
  logic [7:0] cfg_data_i;

  text_command_decoder_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  // Decoder state as the testbench predicts it.
  logic            clock_on_q;
  logic            display_on_q;
  logic [7:0]      contrast_q;
  logic [6:0][7:0] window_q;
  int              window_fill;
  logic [2:0][7:0] head_q;
  int              head_cnt;

  out_t        expected_actions[$];
  out_t        exp_head;
  logic [7:0]  pkt_bytes[$];
  int          mismatches;
  int unsigned src_idle_pct;
  int unsigned sink_stall_pct;
  logic        holding;
  int          quiet_cycles;
  event        hold_go;

  wire in_fire = in_valid_i && !in_stall_o;
  wire out_fire = out_valid_o && !out_stall_i;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic bit is_dec(input logic [8:0] c);
    return !c[8] && c[7:4] == DIGIT_HI && c[3:0] <= DIGIT_MAX;
  endfunction

  // Decides one byte position from up to eight bytes; NO_CHAR marks bytes past the end.
  function automatic bit decode_pos(input logic [7:0][8:0] c, output out_t r);
    logic [3:0] code;
    bit         known;
    int         val;
    r = '0;
    if (c[0] == CHR_LS) begin
      if (c[1] == CHR_LC && clock_on_q) begin
        if (c[2] == CHR_UY) begin
          if (is_dec(c[3]) && is_dec(c[4]) && is_dec(c[5]) && is_dec(c[6]) &&
              c[7] == CHR_LE) begin
            val = c[3][3:0] * 1000 + c[4][3:0] * 100 + c[5][3:0] * 10 + c[6][3:0];
            r.action = ACT_YEAR;
            r.action_value = 14'(val);
            return 1'b1;
          end
          return 1'b0;
        end
        known = 1'b1;
        code = ACT_SEC;
        case (c[2])
          CHR_LS: code = ACT_SEC;
          CHR_LM: code = ACT_MIN;
          CHR_LH: code = ACT_HOUR;
          CHR_LD: code = ACT_DAY;
          CHR_UM: code = ACT_MONTH;
          default: known = 1'b0;
        endcase
        if (known && is_dec(c[3]) && is_dec(c[4]) && c[5] == CHR_LE) begin
          val = c[3][3:0] * 10 + c[4][3:0];
          r.action = code;
          r.action_value = 14'(val);
          return 1'b1;
        end
        return 1'b0;
      end
      if (c[1] == CHR_LO && display_on_q && c[3] == CHR_LE) begin
        if (c[2] == CHR_LI) begin
          contrast_q = (contrast_q < CONTRAST_UP_LIMIT) ? contrast_q + CONTRAST_STEP
                                                        : CONTRAST_MAX;
        end else if (c[2] == CHR_LD) begin
          contrast_q = (contrast_q >= CONTRAST_STEP) ? contrast_q - CONTRAST_STEP
                                                     : CONTRAST_MIN;
        end else begin
          return 1'b0;
        end
        r.action = ACT_CONTRAST;
        r.action_value = {6'd0, contrast_q};
        return 1'b1;
      end
      return 1'b0;
    end
    if (c[0] == CHR_LO || c[0] == CHR_UO) begin
      if (c[1] == ((c[0] == CHR_LO) ? CHR_LN : CHR_UN)) begin
        r.action = ACT_LED_ON;
        r.status_first = head_q[0];
        r.status_second = head_q[1];
        return 1'b1;
      end
      if (c[1] == ((c[0] == CHR_LO) ? CHR_LF : CHR_UF) && c[2] == c[1]) begin
        r.action = ACT_LED_OFF;
        r.status_first = head_q[0];
        r.status_second = head_q[1];
        r.status_third = head_q[2];
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic void predict_beat(input logic [7:0] b, input logic eop);
    logic [7:0][7:0] held;
    logic [7:0][8:0] look;
    out_t            act;
    out_t            batch[$];
    int              n;
    held = '0;
    for (int i = 0; i < window_fill; i++) held[i] = window_q[i];
    held[window_fill] = b;
    n = window_fill + 1;
    if (head_cnt < 3) begin
      head_q[head_cnt] = b;
      head_cnt++;
    end
    if (eop) begin
      for (int p = 0; p < n; p++) begin
        for (int k = 0; k < LOOKAHEAD; k++) begin
          if (p + k < n) begin
            look[k] = {1'b0, held[p + k]};
          end else begin
            look[k] = NO_CHAR;
          end
        end
        if (decode_pos(look, act)) batch.push_back(act);
      end
      window_q = '0;
      window_fill = 0;
      head_q = '0;
      head_cnt = 0;
    end else if (n == LOOKAHEAD) begin
      for (int k = 0; k < LOOKAHEAD; k++) look[k] = {1'b0, held[k]};
      if (decode_pos(look, act)) batch.push_back(act);
      for (int i = 0; i < LOOKAHEAD - 1; i++) window_q[i] = held[i + 1];
      window_fill = LOOKAHEAD - 1;
    end else begin
      for (int i = 0; i < n; i++) window_q[i] = held[i];
      window_fill = n;
    end
    if (batch.size() > 0) batch[batch.size() - 1].last_of_run = 1'b1;
    foreach (batch[i]) expected_actions.push_back(batch[i]);
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatches < PRINT_LIMIT) begin
      $display("%0t: mismatch in %s: got %0d, want %0d", $time, what, got, want);
    end
    mismatches++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_fire) begin
      if (expected_actions.size() == 0) begin
        report_mismatch("unexpected action", out_data_o.action, -1);
      end else begin
        exp_head = expected_actions.pop_front();
        if (out_data_o.action !== exp_head.action)
          report_mismatch("action", out_data_o.action, exp_head.action);
        if (out_data_o.action_value !== exp_head.action_value)
          report_mismatch("action_value", out_data_o.action_value, exp_head.action_value);
        if (out_data_o.status_first !== exp_head.status_first)
          report_mismatch("status_first", out_data_o.status_first, exp_head.status_first);
        if (out_data_o.status_second !== exp_head.status_second)
          report_mismatch("status_second", out_data_o.status_second, exp_head.status_second);
        if (out_data_o.status_third !== exp_head.status_third)
          report_mismatch("status_third", out_data_o.status_third, exp_head.status_third);
        if (out_data_o.last_of_run !== exp_head.last_of_run)
          report_mismatch("last_of_run", out_data_o.last_of_run, exp_head.last_of_run);
      end
    end
  end

  always @(posedge clk_i) begin
    if (holding) begin
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < sink_stall_pct);
    end
  end

  initial begin
    holding <= 1'b0;
    forever begin
      @(hold_go);
      holding <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk_i);
      holding <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || in_fire || out_fire) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic send_beat(input logic [7:0] b, input logic eop);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= '{rx_byte: b, end_of_packet: eop};
    do @(posedge clk_i); while (in_stall_o);
    predict_beat(b, eop);
  endtask

  function automatic void add_text(input string s);
    for (int i = 0; i < s.len(); i++) pkt_bytes.push_back(s[i]);
  endfunction

  task automatic send_packet();
    foreach (pkt_bytes[i]) send_beat(pkt_bytes[i], i == pkt_bytes.size() - 1);
    pkt_bytes.delete();
  endtask

  task automatic send_text(input string s);
    add_text(s);
    send_packet();
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (expected_actions.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_config(input logic clk_on, input logic disp_on, input logic [7:0] start);
    cfg_we_i <= 1'b1;
    cfg_index_i <= CFG_CLOCK_EN;
    cfg_data_i <= {7'($urandom), clk_on};
    @(posedge clk_i);
    cfg_index_i <= CFG_DISPLAY_EN;
    cfg_data_i <= {7'($urandom), disp_on};
    @(posedge clk_i);
    cfg_index_i <= CFG_SPARE;
    cfg_data_i <= 8'($urandom);
    @(posedge clk_i);
    cfg_index_i <= CFG_CONTRAST;
    cfg_data_i <= start;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    clock_on_q = clk_on;
    display_on_q = disp_on;
    contrast_q = start;
  endtask

  task automatic send_random_packet(inout int sent);
    string clk_sel;
    string near;
    int    cut;
    clk_sel = "smhdM";
    near = "scoOnNfFeYidmhM0123456789";
    repeat ($urandom_range(1, 4)) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          add_text("sc");
          pkt_bytes.push_back(clk_sel[$urandom_range(clk_sel.len() - 1)]);
          repeat (2) pkt_bytes.push_back({DIGIT_HI, 4'($urandom_range(9))});
          pkt_bytes.push_back(CHR_LE);
        end
        3: begin
          add_text("scY");
          repeat (4) pkt_bytes.push_back({DIGIT_HI, 4'($urandom_range(9))});
          pkt_bytes.push_back(CHR_LE);
          if ($urandom_range(3) == 0)
            pkt_bytes[pkt_bytes.size() - 1 - $urandom_range(1, 4)] = 8'($urandom);
        end
        4: begin
          add_text("so");
          pkt_bytes.push_back($urandom_range(1) ? CHR_LI : CHR_LD);
          pkt_bytes.push_back(CHR_LE);
        end
        5: begin
          case ($urandom_range(4))
            0: add_text("on");
            1: add_text("ON");
            2: add_text("off");
            3: add_text("OFF");
            default: add_text("oN");
          endcase
        end
        6, 7: begin
          repeat ($urandom_range(1, 6)) pkt_bytes.push_back(8'($urandom));
        end
        default: begin
          repeat ($urandom_range(1, 5)) pkt_bytes.push_back(near[$urandom_range(near.len() - 1)]);
        end
      endcase
    end
    if ($urandom_range(7) == 0) pkt_bytes[$urandom_range(pkt_bytes.size() - 1)] = 8'($urandom);
    if ($urandom_range(4) == 0) begin
      cut = $urandom_range(1, 3);
      while (cut > 0 && pkt_bytes.size() > 1) begin
        void'(pkt_bytes.pop_back());
        cut--;
      end
    end
    sent += pkt_bytes.size();
    send_packet();
  endtask

  task automatic test_clock_cmds();
    send_text("scs00escY9999e");
    send_text("scY1:34escM99e");
    send_text("scY0");
  endtask

  task automatic test_display_cmds();
    send_text("soiesode");
    settle();
    set_config(1'b1, 1'b1, 8'h00);
    send_text("sode");
  endtask

  task automatic test_led_cmds();
    send_text("ON");
    send_text("x9OFFon");
  endtask

  task automatic test_disabled_cmds();
    settle();
    set_config(1'b0, 1'b0, 8'h40);
    send_text("scs12esoie");
  endtask

  task automatic test_backpressure();
    settle();
    set_config(1'b1, 1'b1, 8'hDE);
    src_idle_pct = 0;
    sink_stall_pct = 0;
    -> hold_go;
    send_text("onOFFscs30escY2024esoiesodeoffONscM12eon");
  endtask

  task automatic run_phase(input int unsigned src_pct, input int unsigned sink_pct,
                           input logic clk_on, input logic disp_on,
                           input logic [7:0] start, input int nbytes);
    int sent;
    sent = 0;
    settle();
    set_config(clk_on, disp_on, start);
    src_idle_pct = src_pct;
    sink_stall_pct = sink_pct;
    while (sent < nbytes) send_random_packet(sent);
  endtask

  task automatic test_random_traffic();
    run_phase(0, 0, 1'b1, 1'b1, 8'h80, 60);
    run_phase(60, 0, 1'b0, 1'b1, 8'h00, 60);
    run_phase(0, 60, 1'b1, 1'b0, 8'hFF, 60);
    run_phase(25, 25, 1'b1, 1'b1, 8'hE5, 60);
  endtask

  initial begin
    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    in_data_i <= '0;
    out_stall_i <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_index_i <= CFG_CLOCK_EN;
    cfg_data_i <= '0;
    mismatches = 0;
    src_idle_pct = 0;
    sink_stall_pct = 0;
    clock_on_q = 1'b1;
    display_on_q = 1'b1;
    contrast_q = CONTRAST_RESET;
    window_q = '0;
    window_fill = 0;
    head_q = '0;
    head_cnt = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_clock_cmds();
    test_display_cmds();
    test_led_cmds();
    test_disabled_cmds();
    test_backpressure();
    test_random_traffic();

    settle();
    if (expected_actions.size() != 0)
      report_mismatch("missing actions", 0, expected_actions.size());
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
